/* hdl/assert_macros.svh */
// assertion helpers used by the parser rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define CFR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// expression never true outside reset
`define CFR_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition");

`else

`define CFR_ASSERT(label, clk, rst_n, prop)
`define CFR_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

/* hdl/cfr_pkg.sv */
`default_nettype none

package cfr_pkg;

  localparam int unsigned MaxPayload = 27;
  localparam int unsigned LenW = $clog2(MaxPayload + 1);
  localparam int unsigned MinData = 4;

  localparam logic [7:0] HdrFirst  = 8'hAA;
  localparam logic [7:0] HdrSecond = 8'h55;
  localparam logic [7:0] CmdMotor  = 8'hF2;
  localparam logic [7:0] CmdRemote = 8'h02;

  localparam logic KindMotor  = 1'b0;
  localparam logic KindRemote = 1'b1;

  typedef struct packed {
    logic        frame_kind;
    logic [15:0] motor_speed;
    logic [7:0]  motor_temperature;
    logic [7:0]  motor_fault;
    logic [31:0] remote_word;
  } cfr_result_t;

endpackage

`default_nettype wire

/* hdl/checksummed_frame_receiver.sv */
// checksummed frame receiver
// input channel: in_valid_i / in_ready_o with one received byte in rx_byte_i.
// output channel: out_valid_o / out_ready_i with one decoded frame per
// transfer: frame_kind_o 0 gives motor speed, temperature and fault, kind 1
// gives the four raw remote command bytes, byte 0 in bits 7..0. unused
// fields of a result read zero.
// frames are aa 55 cmd len payload sum; a bad length or checksum, or a
// command other than f2 or 02, or fewer than 4 payload bytes, yields no
// transfer on the output.
// one byte is taken every cycle while the output is not stalled: the byte
// lands in an input register, the parser state machine consumes it from
// there and, on a frame's checksum byte, loads the result register, which
// drives the output.
// when the receiver stalls, the result register holds and the input
// register fills; bytes keep flowing while the result register is free or
// being drained in the same cycle.
// reset puts the parser back to hunting for the first header byte and
// empties both registers.
`default_nettype none

module checksummed_frame_receiver (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             frame_kind_o,
  output logic [15:0]      motor_speed_o,
  output logic [7:0]       motor_temperature_o,
  output logic [7:0]       motor_fault_o,
  output logic [31:0]      remote_word_o
);
  import cfr_pkg::*;

  logic        byte_valid;
  logic [7:0]  byte_val;
  logic        take;
  logic        out_free;
  logic        res_valid;
  cfr_result_t res;
  cfr_result_t res_out;

  assign take = byte_valid && out_free;

  cfr_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (take),
    .valid_o    (byte_valid),
    .byte_o     (byte_val)
  );

  cfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .byte_i      (byte_val),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cfr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .ready_o     (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign frame_kind_o        = res_out.frame_kind;
  assign motor_speed_o       = res_out.motor_speed;
  assign motor_temperature_o = res_out.motor_temperature;
  assign motor_fault_o       = res_out.motor_fault;
  assign remote_word_o       = res_out.remote_word;

endmodule

`default_nettype wire

/* hdl/cfr_in_stage.sv */
`default_nettype none

module cfr_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       take_i,
  output logic            valid_o,
  output logic [7:0]      byte_o
);
  import cfr_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  // slot frees up in the same cycle the parser consumes it
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (take_i) valid_d = 1'b0;
    if (in_valid_i && in_ready_o) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) byte_q <= rx_byte_i;
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

/* hdl/cfr_parser.sv */
`default_nettype none
`include "assert_macros.svh"

module cfr_parser (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           take_i,
  input  wire logic [7:0]     byte_i,
  output logic                res_valid_o,
  output cfr_pkg::cfr_result_t res_o
);
  import cfr_pkg::*;

  typedef enum logic [2:0] {
    PhHunt1,
    PhHunt2,
    PhCmd,
    PhLen,
    PhData,
    PhCheck
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [7:0]        command_q, command_d;
  logic [LenW-1:0]   length_q, length_d;
  logic [LenW-1:0]   seen_q, seen_d;
  logic [7:0]        sum_q, sum_d;
  logic [31:0]       first_q, first_d;
  logic              frame_ok;

  assign frame_ok = (byte_i == sum_q) && (length_q >= LenW'(MinData))
                    && ((command_q == CmdMotor) || (command_q == CmdRemote));

  always_comb begin
    phase_d   = phase_q;
    command_d = command_q;
    length_d  = length_q;
    seen_d    = seen_q;
    sum_d     = sum_q;
    first_d   = first_q;
    if (take_i) begin
      case (phase_q)
        PhHunt2: begin
          if (byte_i == HdrSecond)     phase_d = PhCmd;
          else if (byte_i == HdrFirst) phase_d = PhHunt2;
          else                         phase_d = PhHunt1;
        end
        PhCmd: begin
          command_d = byte_i;
          sum_d     = byte_i;
          phase_d   = PhLen;
        end
        PhLen: begin
          length_d = byte_i[LenW-1:0];
          seen_d   = '0;
          first_d  = '0;
          if (byte_i > 8'(MaxPayload)) begin
            phase_d = PhHunt1;
          end else begin
            sum_d   = sum_q + byte_i;
            phase_d = (byte_i == 8'd0) ? PhCheck : PhData;
          end
        end
        PhData: begin
          if (seen_q < LenW'(MinData)) begin
            first_d[8*seen_q[1:0] +: 8] = byte_i;
          end
          sum_d  = sum_q + byte_i;
          seen_d = seen_q + LenW'(1);
          if (seen_d >= length_q) phase_d = PhCheck;
        end
        PhCheck: phase_d = PhHunt1;
        default: phase_d = (byte_i == HdrFirst) ? PhHunt2 : PhHunt1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt1;
      command_q <= '0;
      length_q  <= '0;
      seen_q    <= '0;
      sum_q     <= '0;
      first_q   <= '0;
    end else begin
      phase_q   <= phase_d;
      command_q <= command_d;
      length_q  <= length_d;
      seen_q    <= seen_d;
      sum_q     <= sum_d;
      first_q   <= first_d;
    end
  end

  // result comes out on the checksum byte
  assign res_valid_o = take_i && (phase_q == PhCheck) && frame_ok;

  always_comb begin
    res_o = '0;
    if (command_q == CmdMotor) begin
      res_o.frame_kind        = KindMotor;
      res_o.motor_speed       = {first_q[7:0], first_q[15:8]};
      res_o.motor_temperature = first_q[23:16];
      res_o.motor_fault       = first_q[31:24];
    end else begin
      res_o.frame_kind  = KindRemote;
      res_o.remote_word = first_q;
    end
  end

  `CFR_ASSERT(a_data_count, clk_i, rst_ni, (phase_q == PhData) |-> (seen_q < length_q))
  `CFR_ASSERT(a_check_to_hunt, clk_i, rst_ni,
              (take_i && phase_q == PhCheck) |=> (phase_q == PhHunt1))
  `CFR_ASSERT_NEVER(a_short_result, clk_i, rst_ni,
                    res_valid_o && (length_q < LenW'(MinData)))
  `CFR_ASSERT(a_len_bound, clk_i, rst_ni,
              (phase_q == PhData || phase_q == PhCheck) |-> (length_q <= LenW'(MaxPayload)))

endmodule

`default_nettype wire

/* hdl/cfr_out_stage.sv */
`default_nettype none

module cfr_out_stage (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire cfr_pkg::cfr_result_t res_i,
  output logic                      ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output cfr_pkg::cfr_result_t      res_o
);
  import cfr_pkg::*;

  logic        valid_q, valid_d;
  cfr_result_t res_q;

  assign ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) valid_d = 1'b0;
    if (load_i) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire
